[src/circular_list_deque_assert.svh]
// ----------------------------------------------------------------------------
// circular_list_deque_assert.svh
// Assertion macros for the deque checkers.
// ----------------------------------------------------------------------------
`ifndef CIRCULAR_LIST_DEQUE_ASSERT_SVH
`define CIRCULAR_LIST_DEQUE_ASSERT_SVH

// same-cycle implication, disabled in reset
`define CLD_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define CLD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/cld_pkg.sv]
// ----------------------------------------------------------------------------
// cld_pkg
// Shared types and codes of the circular list deque.
// ----------------------------------------------------------------------------
package cld_pkg;

    localparam int DEPTH_DEF      = 16;
    localparam int DATA_WIDTH_DEF = 32;

    localparam int KIND_W   = 3;
    localparam int FIELD_W  = 32;
    localparam int STATUS_W = 2;
    localparam int OCC_W    = 5;

    localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 3'd0;
    localparam logic [KIND_W-1:0] KIND_PUSH_BACK  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_POP_BACK   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_CLEAR      = 3'd4;
    localparam logic [KIND_W-1:0] KIND_DUMP       = 3'd5;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    typedef enum logic [2:0] {
        OP_PUSH_FRONT,
        OP_PUSH_BACK,
        OP_POP_FRONT,
        OP_POP_BACK,
        OP_CLEAR,
        OP_DUMP,
        OP_NOP
    } t_op;

    typedef enum logic [1:0] {
        S_IDLE,
        S_POP,
        S_DUMP
    } t_state;

endpackage

[src/circular_list_deque.sv]
// A command is registered in the intake queue before it is taken; push, clear, empty
//   pops and other one-word commands load the output word when taken, pops after the read.
// Throughput: pushes and clears one per cycle unless stalled; a pop holds the next command
//   until its word loads; dumps, one word per cycle after the first read unless stalled.
// Reset: synchronous, active low; clears front index, count, queue and output valid.
//   Store contents are not cleared and stay undefined until written.
// ----------------------------------------------------------------------------
// circular_list_deque
// Fixed-depth double-ended queue on a ring store with front index and count.
// ----------------------------------------------------------------------------
module circular_list_deque #(
    parameter int DEPTH      = cld_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = cld_pkg::DATA_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [cld_pkg::KIND_W-1:0]        i_kind,
    input  logic signed [cld_pkg::FIELD_W-1:0] i_value,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic signed [cld_pkg::FIELD_W-1:0] o_data,
    output logic [cld_pkg::STATUS_W-1:0]      o_status,
    output logic                              o_last,
    output logic [cld_pkg::OCC_W-1:0]         o_occupancy
);

    logic                  w_cmd_valid;
    cld_pkg::t_op          w_cmd_op;
    logic [DATA_WIDTH-1:0] w_cmd_value;
    logic                  w_take;

    cld_front #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_cld_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_kind      (i_kind),
        .i_value     (i_value),
        .o_cmd_valid (w_cmd_valid),
        .o_cmd_op    (w_cmd_op),
        .o_cmd_value (w_cmd_value),
        .i_take      (w_take)
    );

    cld_back #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_cld_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd_op    (w_cmd_op),
        .i_cmd_value (w_cmd_value),
        .o_take      (w_take),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_data      (o_data),
        .o_status    (o_status),
        .o_last      (o_last),
        .o_occupancy (o_occupancy)
    );

endmodule

[src/cld_ram.sv]
// ----------------------------------------------------------------------------
// cld_ram
// Generic single-write, single-read RAM with registered, enabled read.
// ----------------------------------------------------------------------------
module cld_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[src/cld_front.sv]
// ----------------------------------------------------------------------------
// cld_front
// Command intake: decodes the kind field and queues up to two commands.
// ----------------------------------------------------------------------------
module cld_front #(
    parameter int DATA_WIDTH = cld_pkg::DATA_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [cld_pkg::KIND_W-1:0]        i_kind,
    input  logic signed [cld_pkg::FIELD_W-1:0] i_value,
    output logic                              o_cmd_valid,
    output cld_pkg::t_op                      o_cmd_op,
    output logic [DATA_WIDTH-1:0]             o_cmd_value,
    input  logic                              i_take
);

    cld_pkg::t_op          r_q_op  [2];
    logic [DATA_WIDTH-1:0] r_q_val [2];
    logic                  r_wp;
    logic                  r_rp;
    logic [1:0]            r_cnt;

    cld_pkg::t_op          w_op;
    logic                  w_push;
    logic                  w_pop;

    always_comb begin
        case (i_kind)
            cld_pkg::KIND_PUSH_FRONT: w_op = cld_pkg::OP_PUSH_FRONT;
            cld_pkg::KIND_PUSH_BACK:  w_op = cld_pkg::OP_PUSH_BACK;
            cld_pkg::KIND_POP_FRONT:  w_op = cld_pkg::OP_POP_FRONT;
            cld_pkg::KIND_POP_BACK:   w_op = cld_pkg::OP_POP_BACK;
            cld_pkg::KIND_CLEAR:      w_op = cld_pkg::OP_CLEAR;
            cld_pkg::KIND_DUMP:       w_op = cld_pkg::OP_DUMP;
            default:                  w_op = cld_pkg::OP_NOP;
        endcase
    end

    assign o_stall = (r_cnt == 2'd2);
    assign w_push  = i_valid && !o_stall;
    assign w_pop   = i_take && (r_cnt != 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            case ({w_push, w_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q_op[r_wp]  <= w_op;
            r_q_val[r_wp] <= DATA_WIDTH'($unsigned(i_value));
        end
    end

    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd_op    = r_q_op[r_rp];
    assign o_cmd_value = r_q_val[r_rp];

endmodule

[src/cld_back.sv]
// ----------------------------------------------------------------------------
// cld_back
// Command execution on the ring store, with the output word register.
// ----------------------------------------------------------------------------
module cld_back #(
    parameter int DEPTH      = cld_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = cld_pkg::DATA_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cmd_valid,
    input  cld_pkg::t_op                      i_cmd_op,
    input  logic [DATA_WIDTH-1:0]             i_cmd_value,
    output logic                              o_take,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic signed [cld_pkg::FIELD_W-1:0] o_data,
    output logic [cld_pkg::STATUS_W-1:0]      o_status,
    output logic                              o_last,
    output logic [cld_pkg::OCC_W-1:0]         o_occupancy
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    function automatic logic [AW-1:0] f_before(input logic [AW-1:0] a);
        f_before = (a == '0) ? AW'(DEPTH - 1) : a - 1'b1;
    endfunction

    function automatic logic [AW-1:0] f_after(input logic [AW-1:0] a);
        logic [AW:0] s;
        s = {1'b0, a} + 1'b1;
        f_after = (s >= (AW+1)'(DEPTH)) ? '0 : s[AW-1:0];
    endfunction

    function automatic logic [AW-1:0] f_offset(input logic [AW-1:0] a,
                                               input logic [AW:0]   off);
        logic [AW:0] s;
        s = {1'b0, a} + off;
        if (s >= (AW+1)'(DEPTH)) begin
            s = s - (AW+1)'(DEPTH);
        end
        f_offset = s[AW-1:0];
    endfunction

    cld_pkg::t_state r_state, n_state;
    logic [AW-1:0]   r_front, n_front;
    logic [CW-1:0]   r_count, n_count;
    logic [AW-1:0]   r_idx, n_idx;
    logic            r_out_valid;

    logic signed [cld_pkg::FIELD_W-1:0] r_data;
    logic [cld_pkg::STATUS_W-1:0]       r_status;
    logic                               r_last;
    logic [cld_pkg::OCC_W-1:0]          r_occ;

    logic                         w_out_free;
    logic                         w_empty;
    logic                         w_full;
    logic [AW:0]                  w_idx_nx;
    logic                         w_dump_last;
    logic [DATA_WIDTH-1:0]        w_rdata;

    logic                         w_we;
    logic [AW-1:0]                w_waddr;
    logic                         w_re;
    logic [AW-1:0]                w_raddr;
    logic                         w_ld;
    logic [cld_pkg::FIELD_W-1:0]  w_ld_data;
    logic [cld_pkg::STATUS_W-1:0] w_ld_status;
    logic                         w_ld_last;

    assign w_out_free  = !r_out_valid || !i_stall;
    assign w_empty     = (r_count == '0);
    assign w_full      = (r_count == FULL_CNT);
    assign w_idx_nx    = {1'b0, r_idx} + 1'b1;
    assign w_dump_last = (w_idx_nx == (AW+1)'(r_count));

    cld_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_cld_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (i_cmd_value),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            cld_pkg::S_IDLE: begin
                if (i_cmd_valid && w_out_free && !w_empty) begin
                    if (i_cmd_op inside {cld_pkg::OP_POP_FRONT, cld_pkg::OP_POP_BACK}) begin
                        n_state = cld_pkg::S_POP;
                    end else if (i_cmd_op == cld_pkg::OP_DUMP) begin
                        n_state = cld_pkg::S_DUMP;
                    end
                end
            end
            cld_pkg::S_POP: begin
                if (w_out_free) begin
                    n_state = cld_pkg::S_IDLE;
                end
            end
            cld_pkg::S_DUMP: begin
                if (w_out_free && w_dump_last) begin
                    n_state = cld_pkg::S_IDLE;
                end
            end
            default: n_state = cld_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        n_front     = r_front;
        n_count     = r_count;
        n_idx       = r_idx;
        o_take      = 1'b0;
        w_we        = 1'b0;
        w_waddr     = r_front;
        w_re        = 1'b0;
        w_raddr     = r_front;
        w_ld        = 1'b0;
        w_ld_data   = '0;
        w_ld_status = cld_pkg::ST_OK;
        w_ld_last   = 1'b1;
        case (r_state)
            cld_pkg::S_IDLE: begin
                if (i_cmd_valid && w_out_free) begin
                    o_take = 1'b1;
                    case (i_cmd_op)
                        cld_pkg::OP_PUSH_FRONT: begin
                            w_ld = 1'b1;
                            if (w_full) begin
                                w_ld_status = cld_pkg::ST_FULL;
                            end else begin
                                w_we    = 1'b1;
                                w_waddr = f_before(r_front);
                                n_front = f_before(r_front);
                                n_count = r_count + 1'b1;
                            end
                        end
                        cld_pkg::OP_PUSH_BACK: begin
                            w_ld = 1'b1;
                            if (w_full) begin
                                w_ld_status = cld_pkg::ST_FULL;
                            end else begin
                                w_we    = 1'b1;
                                w_waddr = f_offset(r_front, (AW+1)'(r_count));
                                n_count = r_count + 1'b1;
                            end
                        end
                        cld_pkg::OP_POP_FRONT: begin
                            if (w_empty) begin
                                w_ld        = 1'b1;
                                w_ld_status = cld_pkg::ST_EMPTY;
                            end else begin
                                w_re    = 1'b1;
                                w_raddr = r_front;
                                n_front = f_after(r_front);
                                n_count = r_count - 1'b1;
                            end
                        end
                        cld_pkg::OP_POP_BACK: begin
                            if (w_empty) begin
                                w_ld        = 1'b1;
                                w_ld_status = cld_pkg::ST_EMPTY;
                            end else begin
                                w_re    = 1'b1;
                                w_raddr = f_offset(r_front, (AW+1)'(r_count) - 1'b1);
                                n_count = r_count - 1'b1;
                            end
                        end
                        cld_pkg::OP_CLEAR: begin
                            w_ld    = 1'b1;
                            n_front = '0;
                            n_count = '0;
                        end
                        cld_pkg::OP_DUMP: begin
                            if (w_empty) begin
                                w_ld        = 1'b1;
                                w_ld_status = cld_pkg::ST_EMPTY;
                            end else begin
                                w_re    = 1'b1;
                                w_raddr = r_front;
                                n_idx   = '0;
                            end
                        end
                        default: begin
                            w_ld = 1'b1;
                        end
                    endcase
                end
            end
            cld_pkg::S_POP: begin
                if (w_out_free) begin
                    w_ld      = 1'b1;
                    w_ld_data = cld_pkg::FIELD_W'(w_rdata);
                end
            end
            cld_pkg::S_DUMP: begin
                if (w_out_free) begin
                    w_ld      = 1'b1;
                    w_ld_data = cld_pkg::FIELD_W'(w_rdata);
                    w_ld_last = w_dump_last;
                    if (!w_dump_last) begin
                        n_idx   = w_idx_nx[AW-1:0];
                        w_re    = 1'b1;
                        w_raddr = f_offset(r_front, w_idx_nx);
                    end
                end
            end
            default: begin
                w_ld = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= cld_pkg::S_IDLE;
            r_front     <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_front <= n_front;
            r_count <= n_count;
            if (w_ld) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        if (w_ld) begin
            r_data   <= $signed(w_ld_data);
            r_status <= w_ld_status;
            r_last   <= w_ld_last;
            r_occ    <= cld_pkg::OCC_W'(n_count);
        end
    end

    assign o_valid     = r_out_valid;
    assign o_data      = r_data;
    assign o_status    = r_status;
    assign o_last      = r_last;
    assign o_occupancy = r_occ;

endmodule

[src/cld_checker.sv]
// ----------------------------------------------------------------------------
// cld_checker
// Port-level checks of the deque output words, bound to the top level.
// ----------------------------------------------------------------------------
`include "circular_list_deque_assert.svh"

module cld_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_valid,
    input logic                               o_stall,
    input logic [cld_pkg::KIND_W-1:0]         i_kind,
    input logic signed [cld_pkg::FIELD_W-1:0] i_value,
    input logic                               o_valid,
    input logic                               i_stall,
    input logic signed [cld_pkg::FIELD_W-1:0] o_data,
    input logic [cld_pkg::STATUS_W-1:0]       o_status,
    input logic                               o_last,
    input logic [cld_pkg::OCC_W-1:0]          o_occupancy
);

    logic w_in_word;
    assign w_in_word = i_valid && !o_stall && (i_kind != '0 || i_value != '0 || 1'b1);

    `CLD_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_data) && $stable(o_status) && $stable(o_last) && $stable(o_occupancy), "stalled output word changed")

    `CLD_ASSERT_SAME(a_full_word, i_clk, i_rst_n, o_valid && (o_status == cld_pkg::ST_FULL), o_last && (o_data == '0), "full status on a non-final or data word")

    `CLD_ASSERT_SAME(a_empty_word, i_clk, i_rst_n, o_valid && (o_status == cld_pkg::ST_EMPTY), o_last && (o_data == '0) && (o_occupancy == '0), "empty status with data or occupancy")

    `CLD_ASSERT_SAME(a_dump_body, i_clk, i_rst_n, o_valid && !o_last, o_status == cld_pkg::ST_OK, "non-final word without ok status")

    `CLD_ASSERT_NEXT(a_status_code, i_clk, i_rst_n, w_in_word || o_valid, !o_valid || (o_status == cld_pkg::ST_OK) || (o_status == cld_pkg::ST_EMPTY) || (o_status == cld_pkg::ST_FULL), "undefined status code")

endmodule

bind circular_list_deque cld_checker u_cld_checker (.*);

[tb/circular_list_deque_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// circular_list_deque_tb
// Self-checking bench for the fixed-depth deque. A directed run covers empty
// pops and dumps, a fill to full with field extremes, dropped pushes, a full
// dump, spare kinds and clear. A random run alternates fill-biased and
// drain-biased phases. Every output word is checked against a ring model.
// ----------------------------------------------------------------------------
module circular_list_deque_tb;

    localparam int RING_DEPTH   = cld_pkg::DEPTH_DEF;
    localparam int IDX_W        = $clog2(RING_DEPTH);
    localparam int RANDOM_CMDS  = 100;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 20;
    localparam int PRINT_CAP    = 50;

    localparam logic [cld_pkg::KIND_W-1:0] KIND_SPARE_LO = 3'd6;
    localparam logic [cld_pkg::KIND_W-1:0] KIND_SPARE_HI = 3'd7;

    typedef struct {
        logic [cld_pkg::KIND_W-1:0]         kind;
        logic signed [cld_pkg::FIELD_W-1:0] value;
    } t_deque_cmd;

    typedef struct {
        logic signed [cld_pkg::FIELD_W-1:0] data;
        logic [cld_pkg::STATUS_W-1:0]       status;
        logic                               last;
        logic [cld_pkg::OCC_W-1:0]          occupancy;
    } t_deque_word;

    logic                               i_clk   = 1'b0;
    logic                               i_rst_n = 1'b0;
    logic                               i_valid = 1'b0;
    logic                               o_stall;
    logic [cld_pkg::KIND_W-1:0]         i_kind  = '0;
    logic signed [cld_pkg::FIELD_W-1:0] i_value = '0;
    logic                               o_valid;
    logic                               i_stall = 1'b0;
    logic signed [cld_pkg::FIELD_W-1:0] o_data;
    logic [cld_pkg::STATUS_W-1:0]       o_status;
    logic                               o_last;
    logic [cld_pkg::OCC_W-1:0]          o_occupancy;

    t_deque_cmd  pending_cmds[$];
    t_deque_word expected_words[$];
    t_deque_cmd  next_cmd;
    t_deque_word want;

    logic signed [cld_pkg::FIELD_W-1:0] ring_store [RING_DEPTH];
    logic [IDX_W-1:0]                   ring_front = '0;
    logic [cld_pkg::OCC_W-1:0]          ring_count = '0;

    int error_count = 0;
    int cycle_count = 0;
    int burst_left  = 0;
    int idle_left   = 0;
    int stall_left  = 0;

    circular_list_deque DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_kind      (i_kind),
        .i_value     (i_value),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_data      (o_data),
        .o_status    (o_status),
        .o_last      (o_last),
        .o_occupancy (o_occupancy)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    task automatic report_error(input string msg);
        if (error_count < PRINT_CAP) begin
            $display("cycle %0d: %s", cycle_count, msg);
        end
        error_count++;
    endtask

    function automatic void apply_command(input logic [cld_pkg::KIND_W-1:0] kind,
                                          input logic signed [cld_pkg::FIELD_W-1:0] value);
        t_deque_word w;
        int          i;
        w = '{data: '0, status: cld_pkg::ST_OK, last: 1'b1, occupancy: '0};
        case (kind)
            cld_pkg::KIND_PUSH_FRONT: begin
                if (ring_count == RING_DEPTH) begin
                    w.status = cld_pkg::ST_FULL;
                end else begin
                    ring_front = ring_front - 1'b1;
                    ring_store[ring_front] = value;
                    ring_count++;
                end
            end
            cld_pkg::KIND_PUSH_BACK: begin
                if (ring_count == RING_DEPTH) begin
                    w.status = cld_pkg::ST_FULL;
                end else begin
                    ring_store[ring_front + IDX_W'(ring_count)] = value;
                    ring_count++;
                end
            end
            cld_pkg::KIND_POP_FRONT: begin
                if (ring_count == 0) begin
                    w.status = cld_pkg::ST_EMPTY;
                end else begin
                    w.data = ring_store[ring_front];
                    ring_front = ring_front + 1'b1;
                    ring_count--;
                end
            end
            cld_pkg::KIND_POP_BACK: begin
                if (ring_count == 0) begin
                    w.status = cld_pkg::ST_EMPTY;
                end else begin
                    w.data = ring_store[ring_front + IDX_W'(ring_count - 1'b1)];
                    ring_count--;
                end
            end
            cld_pkg::KIND_CLEAR: begin
                ring_front = '0;
                ring_count = '0;
            end
            cld_pkg::KIND_DUMP: begin
                if (ring_count == 0) begin
                    w.status = cld_pkg::ST_EMPTY;
                end else begin
                    for (i = 0; i < ring_count; i++) begin
                        w.data      = ring_store[ring_front + IDX_W'(i)];
                        w.last      = (i == ring_count - 1);
                        w.occupancy = ring_count;
                        expected_words.push_back(w);
                    end
                    return;
                end
            end
            default: ;
        endcase
        w.occupancy = ring_count;
        expected_words.push_back(w);
    endfunction

    function automatic logic signed [cld_pkg::FIELD_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return 32'sh7fffffff;
            1:       return 32'sh80000000;
            2:       return '0;
            3:       return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic void add_cmd(input logic [cld_pkg::KIND_W-1:0] kind,
                                    input logic signed [cld_pkg::FIELD_W-1:0] value);
        pending_cmds.push_back('{kind: kind, value: value});
    endfunction

    // stimulus
    initial begin
        int n;
        int r;
        int phase_left;
        int push_share;
        add_cmd(cld_pkg::KIND_POP_FRONT, $urandom);
        add_cmd(cld_pkg::KIND_POP_BACK, $urandom);
        add_cmd(cld_pkg::KIND_DUMP, $urandom);
        add_cmd(KIND_SPARE_LO, $urandom);
        add_cmd(cld_pkg::KIND_PUSH_FRONT, 32'sh7fffffff);
        add_cmd(cld_pkg::KIND_PUSH_BACK, 32'sh80000000);
        add_cmd(cld_pkg::KIND_PUSH_FRONT, '0);
        add_cmd(cld_pkg::KIND_PUSH_BACK, '1);
        for (n = 4; n < RING_DEPTH; n++) begin
            add_cmd((n % 2) ? cld_pkg::KIND_PUSH_BACK : cld_pkg::KIND_PUSH_FRONT, $urandom);
        end
        add_cmd(cld_pkg::KIND_PUSH_FRONT, $urandom);
        add_cmd(cld_pkg::KIND_PUSH_BACK, $urandom);
        add_cmd(cld_pkg::KIND_DUMP, $urandom);
        add_cmd(KIND_SPARE_HI, $urandom);
        add_cmd(cld_pkg::KIND_POP_FRONT, $urandom);
        add_cmd(cld_pkg::KIND_POP_BACK, $urandom);
        add_cmd(cld_pkg::KIND_CLEAR, $urandom);

        n = 0;
        phase_left = 0;
        push_share = 60;
        while (n < RANDOM_CMDS) begin
            if (phase_left == 0) begin
                phase_left = $urandom_range(16, 40);
                push_share = (push_share == 60) ? 25 : 60;
            end
            phase_left--;
            r = $urandom_range(0, 99);
            if (r < 2) begin
                add_cmd($urandom_range(0, 1) ? KIND_SPARE_HI : KIND_SPARE_LO, $urandom);
            end else begin
                if (r < 5) begin
                    add_cmd(cld_pkg::KIND_CLEAR, $urandom);
                end else if (r < 13) begin
                    add_cmd(cld_pkg::KIND_DUMP, $urandom);
                end else if (r < 13 + push_share) begin
                    add_cmd($urandom_range(0, 1) ? cld_pkg::KIND_PUSH_BACK
                                                 : cld_pkg::KIND_PUSH_FRONT,
                            pick_value());
                end else begin
                    add_cmd($urandom_range(0, 1) ? cld_pkg::KIND_POP_BACK
                                                 : cld_pkg::KIND_POP_FRONT,
                            $urandom);
                end
                n++;
            end
        end
    end

    // command driver: bursts with random idle gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                apply_command(i_kind, i_value);
            end
            if (!i_valid || !o_stall) begin
                if (idle_left > 0) begin
                    idle_left <= idle_left - 1;
                    i_valid   <= 1'b0;
                end else if (pending_cmds.size() > 0) begin
                    next_cmd = pending_cmds.pop_front();
                    i_valid <= 1'b1;
                    i_kind  <= next_cmd.kind;
                    i_value <= next_cmd.value;
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 12);
                        idle_left  <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // receiver stall pattern: alternating random stall and free runs
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall    <= 1'b0;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
        end else if (i_stall) begin
            i_stall    <= 1'b0;
            stall_left <= $urandom_range(0, 24);
        end else begin
            i_stall    <= 1'b1;
            stall_left <= $urandom_range(0, 7);
        end
    end

    // word monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_words.size() == 0) begin
                report_error($sformatf("unexpected word data %0h status %0d",
                                       o_data, o_status));
            end else begin
                want = expected_words.pop_front();
                if (o_data !== want.data)
                    report_error($sformatf("data %0h, want %0h", o_data, want.data));
                if (o_status !== want.status)
                    report_error($sformatf("status %0d, want %0d", o_status, want.status));
                if (o_last !== want.last)
                    report_error($sformatf("last %0b, want %0b", o_last, want.last));
                if (o_occupancy !== want.occupancy)
                    report_error($sformatf("occupancy %0d, want %0d",
                                           o_occupancy, want.occupancy));
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        do begin
            @(posedge i_clk);
        end while (i_valid || pending_cmds.size() != 0 || expected_words.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0 && expected_words.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

[filelist.f]
+incdir+src
src/cld_pkg.sv
src/cld_ram.sv
src/cld_front.sv
src/cld_back.sv
src/circular_list_deque.sv
src/cld_checker.sv
tb/circular_list_deque_tb.sv
